[rtl/i420mr_pkg.sv]
// Shared types and constants for the I420 frame store with mirrored reads.
package i420mr_pkg;

  // Field widths of a request and a result
  localparam int ACT_W   = 1;
  localparam int PLANE_W = 2;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 7;
  localparam int MODE_W  = 2;
  localparam int PIX_W   = 8;

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = ACT_W + PLANE_W;
  localparam int OUT_TDATA_W = PIX_W;
  localparam int OUT_TUSER_W = 1;

  // Configuration port
  localparam int CFG_W_BITS = 9;
  localparam int CFG_H_BITS = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = 8'd128;

  // Default maximum frame size
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 128;

  // Result queue depth (bounds reads in flight)
  localparam int OFIFO_DEPTH = 8;

  // Request kinds
  localparam logic [ACT_W-1:0] ACT_LOAD = 1'b0;
  localparam logic [ACT_W-1:0] ACT_READ = 1'b1;

  // Plane codes
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  // Bits of mirror_mode
  localparam int MODE_HFLIP_BIT = 0;
  localparam int MODE_VFLIP_BIT = 1;

  // Store access issued by the address mapper
  typedef struct packed {
    logic wr;      // in-range load: write the store
    logic rd;      // in-range read: read the store
    logic result;  // read request: a result is due
    logic err;     // position or plane out of range
  } acc_t;

endpackage

[rtl/i420mr_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module i420mr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/i420mr_map.sv]
// Two-stage address mapper: range check and mirroring, then packed store address.
module i420mr_map #(
  parameter int MAX_WIDTH  = i420mr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = i420mr_pkg::MAX_HEIGHT_DEF,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1),
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT * 3 / 2)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_vld,
  input  logic [i420mr_pkg::ACT_W-1:0]   action,
  input  logic [i420mr_pkg::PLANE_W-1:0] plane,
  input  logic [i420mr_pkg::COL_W-1:0]   column,
  input  logic [i420mr_pkg::ROW_W-1:0]   row,
  input  logic [i420mr_pkg::MODE_W-1:0]  mirror_mode,
  input  logic [i420mr_pkg::PIX_W-1:0]   pixel_in,
  input  logic [WW-1:0]                  eff_w,
  input  logic [HW-1:0]                  eff_h,
  input  logic [AW-1:0]                  base_u,
  input  logic [AW-1:0]                  base_v,
  output i420mr_pkg::acc_t               acc,
  output logic [AW-1:0]                  ram_addr,
  output logic [i420mr_pkg::PIX_W-1:0]   ram_wdata
);
  import i420mr_pkg::*;

  localparam int CCW = (WW > COL_W) ? WW : COL_W;
  localparam int RCW = (HW > ROW_W) ? HW : ROW_W;

  // Stage 1: raw request
  logic               s1_vld_r;
  logic [ACT_W-1:0]   s1_act_r;
  logic [PLANE_W-1:0] s1_plane_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [MODE_W-1:0]  s1_mode_r;
  logic [PIX_W-1:0]   s1_pix_r;

  // Stage 2: mapped source position
  logic               s2_vld_r;
  logic [ACT_W-1:0]   s2_act_r;
  logic               s2_ok_r;
  logic [PLANE_W-1:0] s2_plane_r;
  logic [CCW-1:0]     s2_sx_r;
  logic [RCW-1:0]     s2_sy_r;
  logic [WW-1:0]      s2_pw_r;
  logic [PIX_W-1:0]   s2_pix_r;

  logic [WW-1:0]     pw;
  logic [HW-1:0]     ph;
  logic [CCW-1:0]    col_x;
  logic [RCW-1:0]    row_x;
  logic [MODE_W-1:0] mode_eff;
  logic              plane_ok;
  logic              pos_ok;
  logic [CCW-1:0]    sx;
  logic [RCW-1:0]    sy;

  always_comb begin
    plane_ok = s1_plane_r inside {PLANE_Y, PLANE_U, PLANE_V};
    if (s1_plane_r == PLANE_Y) begin
      pw = eff_w;
      ph = eff_h;
    end else begin
      pw = eff_w >> 1;
      ph = eff_h >> 1;
    end
    col_x    = CCW'(s1_col_r);
    row_x    = RCW'(s1_row_r);
    pos_ok   = (col_x < CCW'(pw)) && (row_x < RCW'(ph));
    // loads always land at the plain position
    mode_eff = (s1_act_r == ACT_READ) ? s1_mode_r : '0;
    sx = mode_eff[MODE_HFLIP_BIT] ? (CCW'(pw) - CCW'(1) - col_x) : col_x;
    sy = mode_eff[MODE_VFLIP_BIT] ? (RCW'(ph) - RCW'(1) - row_x) : row_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      s1_act_r   <= action;
      s1_plane_r <= plane;
      s1_col_r   <= column;
      s1_row_r   <= row;
      s1_mode_r  <= mirror_mode;
      s1_pix_r   <= pixel_in;
    end
    s2_act_r   <= s1_act_r;
    s2_ok_r    <= plane_ok && pos_ok;
    s2_plane_r <= s1_plane_r;
    s2_sx_r    <= sx;
    s2_sy_r    <= sy;
    s2_pw_r    <= pw;
    s2_pix_r   <= s1_pix_r;
  end

  // Packed address: plane base + row * plane width + column
  logic [AW-1:0]       base;
  logic [RCW+WW-1:0]   row_off;

  always_comb begin
    case (s2_plane_r)
      PLANE_U: base = base_u;
      PLANE_V: base = base_v;
      default: base = '0;
    endcase
    row_off  = (RCW+WW)'(s2_sy_r) * (RCW+WW)'(s2_pw_r);
    ram_addr = base + AW'(row_off) + AW'(s2_sx_r);
  end

  assign ram_wdata  = s2_pix_r;
  assign acc.wr     = s2_vld_r && (s2_act_r == ACT_LOAD) && s2_ok_r;
  assign acc.rd     = s2_vld_r && (s2_act_r == ACT_READ) && s2_ok_r;
  assign acc.result = s2_vld_r && (s2_act_r == ACT_READ);
  assign acc.err    = !s2_ok_r;

endmodule

[rtl/i420mr_ofifo.sv]
// Small result queue that decouples the store pipeline from the output side.
module i420mr_ofifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = i420mr_pkg::OFIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  assign dout      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

[rtl/i420_frame_mirror_rotate_core.sv]
// Top level: I420 frame store with mirrored / rotated byte reads.
//
// Holds one planar YUV 4:2:0 frame (Y, then U, then V, row by row) in a single
// synchronous RAM of MAX_WIDTH*MAX_HEIGHT*3/2 bytes. A load request writes one
// byte; a read request returns the byte at the position given by the output
// column/row after an optional horizontal mirror, vertical mirror or both
// (180-degree rotation). Out-of-plane positions and plane code 3 give pixel 0
// with range_error set; such loads are dropped. Width and height come from the
// config registers with bit 0 cleared and are capped at the maximum size.
// Rate: one request per cycle while in_tready is high, loads and reads mixed,
// limited by the single RAM port (one access per cycle). A read result passes
// the map, address and RAM read stages, is registered with its error flag and
// is then queued in an 8-entry result queue; up to 8 reads may be outstanding
// before in_tready drops, so output stalls do not reach the input until 8
// reads are outstanding. Loads produce no result.
// Store contents are undefined until written; there is no clearing pass after
// reset. Config writes take effect for requests taken from the same cycle on.
module i420_frame_mirror_rotate_core #(
  parameter int MAX_WIDTH  = i420mr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = i420mr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] column, [14:8] row, [16:15] mirror_mode, [24:17] pixel_in
  input  logic [i420mr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] action, [2:1] plane
  input  logic [i420mr_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] pixel_out
  output logic [i420mr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] range_error
  output logic [i420mr_pkg::OUT_TUSER_W-1:0] out_tuser,
  // config write port
  input  logic                               cfg_we,
  input  logic [i420mr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [i420mr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i420mr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WCW   = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;
  localparam int HCW   = (HW > CFG_H_BITS) ? HW : CFG_H_BITS;
  localparam int LW    = WW + HW + 1;
  localparam int QW    = PIX_W + 1;
  localparam int CNTW  = $clog2(OFIFO_DEPTH + 1);
  localparam logic [WCW-1:0] W_CAP = WCW'(MAX_WIDTH - MAX_WIDTH % 2);
  localparam logic [HCW-1:0] H_CAP = HCW'(MAX_HEIGHT - MAX_HEIGHT % 2);

  // ---------------- config registers and frame geometry ----------------
  logic [CFG_W_BITS-1:0] frame_width_r;
  logic [CFG_H_BITS-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // even size, capped at the maximum
  logic [WCW-1:0] w_even;
  logic [HCW-1:0] h_even;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [LW-1:0]  y_area;

  assign w_even = WCW'({frame_width_r[CFG_W_BITS-1:1], 1'b0});
  assign h_even = HCW'({frame_height_r[CFG_H_BITS-1:1], 1'b0});
  assign eff_w  = WW'((w_even > W_CAP) ? W_CAP : w_even);
  assign eff_h  = HW'((h_even > H_CAP) ? H_CAP : h_even);
  assign y_area = LW'(eff_w) * LW'(eff_h);

  // plane bases; chroma plane = luma / 4 since both sizes are even
  logic [AW-1:0] base_u_r;
  logic [AW-1:0] base_v_r;

  always_ff @(posedge clk) begin
    base_u_r <= AW'(y_area);
    base_v_r <= AW'(y_area + (y_area >> 2));
  end

  // ---------------- request intake ----------------
  logic            in_acc;
  logic            out_acc;
  logic [CNTW-1:0] pend_r, pend_nxt;

  // reads taken but not yet delivered; capped by the result queue size
  assign in_tready = (pend_r < CNTW'(OFIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign pend_nxt  = pend_r + CNTW'(in_acc && (in_tuser[0] == ACT_READ)) - CNTW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // ---------------- address mapping ----------------
  acc_t             acc;
  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0] ram_rdata;

  i420mr_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW),
    .AW         (AW)
  ) u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_vld     (in_acc),
    .action      (in_tuser[0]),
    .plane       (in_tuser[2:1]),
    .column      (in_tdata[7:0]),
    .row         (in_tdata[14:8]),
    .mirror_mode (in_tdata[16:15]),
    .pixel_in    (in_tdata[24:17]),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .base_u      (base_u_r),
    .base_v      (base_v_r),
    .acc         (acc),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata)
  );

  // ---------------- frame store ----------------
  // Loads and reads reach the RAM in request order, one per cycle, so a read
  // always sees every earlier load.
  i420mr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (acc.wr || acc.rd),
    .we    (acc.wr),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // stage aligned with RAM read data
  logic s3_vld_r;
  logic s3_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= acc.result;
    end
  end

  always_ff @(posedge clk) begin
    s3_err_r <= acc.err;
  end

  // ---------------- result queue ----------------
  logic [QW-1:0]   q_din;
  logic [QW-1:0]   q_dout;
  logic [CNTW-1:0] q_count;

  assign q_din = {s3_err_r, s3_err_r ? PIX_W'(0) : ram_rdata};

  i420mr_ofifo #(
    .WIDTH (QW),
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_vld_r),
    .din       (q_din),
    .pop       (out_acc),
    .dout      (q_dout),
    .not_empty (out_tvalid),
    .count     (q_count)
  );

  assign out_tdata    = q_dout[PIX_W-1:0];
  assign out_tuser[0] = q_dout[PIX_W];

  // ---------------- assertions ----------------
  a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CNTW'(OFIFO_DEPTH))
    else $error("outstanding reads exceed result queue");

  a_queue_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= pend_r)
    else $error("result queue holds more than outstanding reads");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc.wr && acc.rd))
    else $error("store written and read in the same cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("range error result with nonzero pixel");

endmodule
